// ----- src/fbsa_pkg.sv -----
// Package for the banded stiffness assembly core: sizes, mode codes, FP64 adder.
// No dependencies.
package fbsa_pkg;
   localparam int MAX_NODES_DEF = 256;
   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int MAX_NPE_DEF = 8;
   localparam int MAX_DPN_DEF = 6;
   localparam int MAX_BAND_DEF = 64;

   localparam logic [1:0] MODE_INC  = 2'd0;
   localparam logic [1:0] MODE_STIF = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic [1:0] CSR_NPE = 2'd0;
   localparam logic [1:0] CSR_DPN = 2'd1;
   localparam logic [1:0] CSR_BW  = 2'd2;

   typedef struct packed {
      logic       oob;
      logic       done;
      logic       twice;
      logic       rd;
   } ctl_type;

   // Leading-zero count of a 56-bit value, 0..56.
   function automatic logic [5:0] lzc56(input logic [55:0] v);
      logic [5:0] n;
      logic       hit;
      n = 6'd56;
      hit = 1'b0;
      for (int i = 55; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n = 6'(55 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // IEEE double add, round to nearest even.
   function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
      logic        sa, sb, sx, sy, sr;
      logic [10:0] ea, eb, ex, ey, er;
      logic [52:0] ma, mb;
      logic [55:0] mx, my, s, sh;
      logic [56:0] sum;
      logic [11:0] d, ee;
      logic [5:0]  lz;
      logic        st, rnd;
      logic [53:0] m;
      logic [63:0] r;
      logic        an, bn, ai, bi;
      sa = a[63]; sb = b[63]; ea = a[62:52]; eb = b[62:52];
      ai = (ea == 11'h7ff); bi = (eb == 11'h7ff);
      an = ai && (a[51:0] != 0); bn = bi && (b[51:0] != 0);
      ma = {(ea != 0), a[51:0]}; mb = {(eb != 0), b[51:0]};
      if (ea == 0) ea = 11'd1;
      if (eb == 0) eb = 11'd1;
      r = '0;
      if (an || bn || (ai && bi && sa != sb)) begin
         r = 64'h7ff8000000000000;
      end else if (ai) begin
         r = a;
      end else if (bi) begin
         r = b;
      end else begin
         if ({ea, ma} >= {eb, mb}) begin
            sx = sa; ex = ea; mx = {ma, 3'b0}; sy = sb; ey = eb; my = {mb, 3'b0};
         end else begin
            sx = sb; ex = eb; mx = {mb, 3'b0}; sy = sa; ey = ea; my = {ma, 3'b0};
         end
         d = {1'b0, ex} - {1'b0, ey};
         if (d > 12'd55) begin
            sh = {55'd0, (my != 0)};
         end else begin
            sh = my >> d;
            st = ((my & ~({56{1'b1}} << d)) != 0);
            sh[0] = sh[0] | st;
         end
         if (sx == sy) sum = {1'b0, mx} + {1'b0, sh};
         else sum = {1'b0, mx} - {1'b0, sh};
         sr = sx;
         if (sum == 0) begin
            r = {(sa & sb), 63'd0};
         end else begin
            if (sum[56]) begin
               s = sum[56:1];
               s[0] = s[0] | sum[0];
               ee = {1'b0, ex} + 12'd1;
            end else begin
               lz = lzc56(sum[55:0]);
               if ({6'd0, lz} >= {1'b0, ex}) lz = 6'(ex - 11'd1);
               s = sum[55:0] << lz;
               ee = {1'b0, ex} - {6'd0, lz};
               if (!s[55]) ee = 12'd0;
            end
            rnd = s[2] && (s[1] || s[0] || s[3]);
            m = {1'b0, s[55:3]} + {53'd0, rnd};
            if (m[53]) begin
               m = m >> 1;
               ee = ee + 12'd1;
            end else if (ee == 0 && m[52]) begin
               ee = 12'd1;
            end
            if (ee >= 12'h7ff) begin
               r = {sr, 11'h7ff, 52'd0};
            end else begin
               er = ee[10:0];
               r = {sr, er, m[51:0]};
            end
         end
      end
      return r;
   endfunction
endpackage

// ----- src/fbsa_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module fbsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/fem_banded_stiffness_assembly_core.sv -----
// Banded stiffness assembly core: incidence RAM, band RAM, FP64 read-modify-write.
// rsp_tvalid rises from S_OUT: modes 0 and 3 go there directly, mode 2 via S_BRD, mode 1
// via S_NA, S_NB, S_GD, S_GE, S_ADR, S_RD, S_ADD, S_WR (looped when added twice, skipped
// when dropped). One request at a time, the next taken once idle and rsp_tvalid is low.
// After reset the band RAM is cleared one entry per cycle, all
// MAX_NODES*MAX_DOF_PER_NODE*MAX_BAND entries, before requests are taken.
// Depends on fbsa_pkg and fbsa_ram.
module fem_banded_stiffness_assembly_core #(
   parameter int MAX_NODES = fbsa_pkg::MAX_NODES_DEF,
   parameter int MAX_ELEMENTS = fbsa_pkg::MAX_ELEMENTS_DEF,
   parameter int MAX_NODES_PER_ELEMENT = fbsa_pkg::MAX_NPE_DEF,
   parameter int MAX_DOF_PER_NODE = fbsa_pkg::MAX_DPN_DEF,
   parameter int MAX_BAND = fbsa_pkg::MAX_BAND_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] mode, [18:2] index, [27:19] node_number, [38:28] element_id,
   // [102:39] stiffness_value, zero fill to 104 bits
   input  logic [103:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] read_value, [64] out_of_band, [65] element_done, zero fill to 72 bits
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import fbsa_pkg::*;

   localparam int INC_DEPTH = MAX_ELEMENTS * MAX_NODES_PER_ELEMENT;
   localparam int MAX_GDOF = MAX_NODES * MAX_DOF_PER_NODE;
   localparam int BAND_DEPTH = MAX_GDOF * MAX_BAND;
   localparam int IAW = $clog2(INC_DEPTH);
   localparam int BAW = $clog2(BAND_DEPTH);
   localparam int FW = 6;
   localparam int TW = 24;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_NA   = 4'd2;
   localparam logic [3:0] S_NB   = 4'd3;
   localparam logic [3:0] S_GD   = 4'd4;
   localparam logic [3:0] S_ADR  = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_ADD  = 4'd7;
   localparam logic [3:0] S_WR   = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;
   localparam logic [3:0] S_BRD  = 4'd10;
   localparam logic [3:0] S_GE   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [BAW-1:0] clr_ff, clr_in;
   logic [3:0] npe_ff;
   logic [2:0] dpn_ff;
   logic [6:0] bw_ff;
   logic [FW-1:0] row_ff, row_in, col_ff, col_in;
   logic [1:0]  mode_ff;
   logic [16:0] idx_ff;
   logic [10:0] elem_ff;
   logic [63:0] val_ff, acc_ff;
   logic [TW-1:0] ga_ff, gb_ff;
   logic [BAW-1:0] t_ff;
   logic [FW-1:0] nla_ff, nlb_ff, ca_ff, cb_ff;
   ctl_type ctl_ff;
   logic [71:0] rsp_ff;
   logic rsp_v_ff;

   logic inc_we;
   logic [IAW-1:0] inc_wa, inc_ra;
   logic [8:0] inc_rd;
   logic band_we;
   logic [BAW-1:0] band_wa, band_ra;
   logic [63:0] band_wd, band_rd;

   fbsa_ram #(.WIDTH(9), .DEPTH(INC_DEPTH)) u_inc (
      .clock(clock), .wr_en(inc_we), .wr_addr(inc_wa), .wr_data(req_tdata[27:19]),
      .rd_addr(inc_ra), .rd_data(inc_rd));
   fbsa_ram #(.WIDTH(64), .DEPTH(BAND_DEPTH)) u_band (
      .clock(clock), .wr_en(band_we), .wr_addr(band_wa), .wr_data(band_wd),
      .rd_addr(band_ra), .rd_data(band_rd));

   logic [3:0] npe_e;
   logic [2:0] dpn_e;
   logic [6:0] bw_e;
   logic [FW-1:0] f_e;
   logic accept;
   logic slot_ok_a, slot_ok_b;
   logic [TW-1:0] slot_a, slot_b, lo, hi;
   logic [TW-1:0] ga_c, gb_c;
   logic drop;

   always_comb begin
      npe_e = (npe_ff == 0) ? 4'd1 :
              ({28'd0, npe_ff} > MAX_NODES_PER_ELEMENT) ? 4'(MAX_NODES_PER_ELEMENT) : npe_ff;
      dpn_e = (dpn_ff == 0) ? 3'd1 :
              ({29'd0, dpn_ff} > MAX_DOF_PER_NODE) ? 3'(MAX_DOF_PER_NODE) : dpn_ff;
      bw_e = ({25'd0, bw_ff} > MAX_BAND) ? 7'(MAX_BAND) : bw_ff;
      f_e = FW'(npe_e * dpn_e);
   end

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_ff;

   // node-local index and component; quotient by reciprocal multiply, exact for r <= 48
   function automatic logic [2*FW-1:0] split(input logic [FW-1:0] r, input logic [2:0] dpn);
      logic [FW-1:0] q, m;
      logic [13:0]   p;
      m = r - FW'(1);
      p = '0;
      case (dpn)
         3'd2: q = m >> 1;
         3'd3: begin
            p = {8'd0, m} * 14'd43;
            q = FW'(p >> 7);
         end
         3'd4: q = m >> 2;
         3'd5: begin
            p = {8'd0, m} * 14'd13;
            q = FW'(p >> 6);
         end
         3'd6: begin
            p = {8'd0, m} * 14'd43;
            q = FW'(p >> 8);
         end
         default: q = m;
      endcase
      return {q, m - q * {3'd0, dpn} + FW'(1)};
   endfunction

   always_comb begin
      slot_a = TW'(elem_ff - 11'd1) * TW'(npe_e) + TW'(nla_ff);
      slot_b = TW'(elem_ff - 11'd1) * TW'(npe_e) + TW'(nlb_ff);
      slot_ok_a = (elem_ff != 0) && (slot_a < TW'(INC_DEPTH));
      slot_ok_b = (elem_ff != 0) && (slot_b < TW'(INC_DEPTH));
      ga_c = ((slot_ok_a ? TW'(inc_rd) : TW'(0)) - TW'(1)) * TW'(dpn_e) + TW'(ca_ff);
      gb_c = ((slot_ok_b ? TW'(inc_rd) : TW'(0)) - TW'(1)) * TW'(dpn_e) + TW'(cb_ff);
      lo = ($signed(ga_ff) < $signed(gb_ff)) ? ga_ff : gb_ff;
      hi = ($signed(ga_ff) < $signed(gb_ff)) ? gb_ff : ga_ff;
      drop = ($signed(lo) < 1) || ($signed(hi) > $signed(TW'(MAX_GDOF))) ||
             ((hi - lo) >= TW'(bw_e));
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      row_in = row_ff;
      col_in = col_ff;
      inc_we = 1'b0;
      inc_wa = req_tdata[IAW+1:2];
      inc_ra = slot_a[IAW-1:0];
      band_we = 1'b0;
      band_wa = t_ff;
      band_wd = acc_ff;
      band_ra = t_ff;
      case (state_ff)
         S_CLR: begin
            band_we = 1'b1;
            band_wa = clr_ff;
            band_wd = '0;
            clr_in = clr_ff + BAW'(1);
            if ({{(32-BAW){1'b0}}, clr_ff} == BAND_DEPTH - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (req_tdata[1:0])
                  MODE_INC: begin
                     inc_we = ({15'd0, req_tdata[18:2]} < INC_DEPTH);
                     state_in = S_OUT;
                  end
                  MODE_STIF: begin
                     if (row_ff < 1 || row_ff > f_e) begin
                        row_in = FW'(1);
                        col_in = FW'(1);
                     end else if (col_ff < row_ff || col_ff > f_e) begin
                        col_in = row_ff;
                     end
                     state_in = S_NA;
                  end
                  MODE_READ: state_in = S_BRD;
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_NA: state_in = S_NB;
         S_NB: begin
            inc_ra = slot_a[IAW-1:0];
            state_in = S_GD;
         end
         S_GD: begin
            inc_ra = slot_b[IAW-1:0];
            state_in = S_GE;
         end
         S_GE: state_in = S_ADR;
         S_ADR: state_in = drop ? S_OUT : S_RD;
         S_RD: state_in = S_ADD;
         S_ADD: state_in = S_WR;
         S_WR: begin
            band_we = 1'b1;
            state_in = ctl_ff.twice ? S_RD : S_OUT;
         end
         S_BRD: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_BRD) band_ra = idx_ff[BAW-1:0];
      if (state_ff == S_ADR && mode_ff == MODE_STIF) begin
         if (col_ff + FW'(1) > f_e) begin
            if (row_ff + FW'(1) > f_e) begin
               row_in = FW'(1);
               col_in = FW'(1);
            end else begin
               row_in = row_ff + FW'(1);
               col_in = row_ff + FW'(1);
            end
         end else begin
            col_in = col_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         npe_ff <= 4'd2;
         dpn_ff <= 3'd2;
         bw_ff <= 7'd64;
         row_ff <= FW'(1);
         col_ff <= FW'(1);
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_NPE: npe_ff <= csr_data[3:0];
               CSR_DPN: dpn_ff <= csr_data[2:0];
               CSR_BW:  bw_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_OUT) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tdata[1:0];
         idx_ff <= req_tdata[18:2];
         elem_ff <= req_tdata[38:28];
         val_ff <= req_tdata[102:39];
         ctl_ff <= '0;
      end
      case (state_ff)
         S_NA: begin
            {nla_ff, ca_ff} <= split(row_ff, dpn_e);
            {nlb_ff, cb_ff} <= split(col_ff, dpn_e);
         end
         S_GD: ga_ff <= ga_c;
         S_GE: gb_ff <= gb_c;
         default: ;
      endcase
      if (state_ff == S_ADR && mode_ff == MODE_STIF) begin
         ctl_ff.oob <= drop;
         ctl_ff.twice <= (row_ff != col_ff) && (ga_ff == gb_ff);
         ctl_ff.done <= (col_ff + FW'(1) > f_e) && (row_ff + FW'(1) > f_e);
         t_ff <= BAW'(lo - TW'(1)) * BAW'(bw_e) + BAW'(hi - lo);
      end
      if (state_ff == S_ADD) acc_ff <= fadd(band_rd, val_ff);
      if (state_ff == S_WR) ctl_ff.twice <= 1'b0;
      if (state_ff == S_OUT) begin
         rsp_ff <= {6'd0, ctl_ff.done, ctl_ff.oob, ctl_ff.rd ? band_rd : 64'd0};
      end
      if (state_ff == S_BRD) ctl_ff.rd <= ({15'd0, idx_ff} < BAND_DEPTH);
   end

`ifndef SYNTH
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !rsp_tvalid) else $error("response during clear");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("response lost");
`endif
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for fem_banded_stiffness_assembly_core: drives incidence,
// stiffness, band-read and mode-3 requests, predicts every response in-line and scores it.
// Depends on fbsa_pkg and the core RTL.
module testbench;
   import fbsa_pkg::*;

   localparam int INC_DEPTH  = MAX_ELEMENTS_DEF * MAX_NPE_DEF;
   localparam int MAX_GDOF   = MAX_NODES_DEF * MAX_DPN_DEF;
   localparam int BAND_DEPTH = MAX_GDOF * MAX_BAND_DEF;
   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct {
      logic [1:0]  mode;
      logic [16:0] idx;
      logic [8:0]  node;
      logic [10:0] elem;
      logic [63:0] val;
   } req_item_type;

   typedef struct {
      logic [63:0] rd;
      logic        oob;
      logic        done;
   } rsp_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [6:0]   csr_data = '0;

   rsp_item_type pending_rsp[$];
   int          errors = 0;
   int          sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   logic [8:0]  inc_tab [INC_DEPTH];
   bit          inc_set [INC_DEPTH];
   logic [63:0] band_acc [int];
   int          band_hits[$];
   int          loc_row = 1;
   int          loc_col = 1;
   logic [3:0]  cfg_npe = 4'd2;
   logic [2:0]  cfg_dpn = 3'd2;
   logic [6:0]  cfg_bw = 7'd64;

   fem_banded_stiffness_assembly_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_npe();
      if (cfg_npe < 1) return 1;
      if (cfg_npe > MAX_NPE_DEF) return MAX_NPE_DEF;
      return cfg_npe;
   endfunction

   function automatic int eff_dpn();
      if (cfg_dpn < 1) return 1;
      if (cfg_dpn > MAX_DPN_DEF) return MAX_DPN_DEF;
      return cfg_dpn;
   endfunction

   function automatic logic [63:0] fp64_sum(input logic [63:0] a, input logic [63:0] b);
      logic ai, bi, an, bn;
      ai = (a[62:52] == 11'h7ff);
      bi = (b[62:52] == 11'h7ff);
      an = ai && (a[51:0] != 0);
      bn = bi && (b[51:0] != 0);
      if (an || bn || (ai && bi && a[63] != b[63])) return 64'h7ff8000000000000;
      if (ai) return a;
      if (bi) return b;
      return $realtobits($bitstoreal(a) + $bitstoreal(b));
   endfunction

   function automatic longint global_dof(input int elem, input int r, input int npe,
                                         input int dpn);
      int     slot;
      longint node;
      node = 0;
      if (elem >= 1) begin
         slot = (elem - 1) * npe + (r - 1) / dpn;
         if (slot < INC_DEPTH) node = inc_tab[slot];
      end
      return (node - 1) * dpn + (r - 1) % dpn + 1;
   endfunction

   function automatic void band_add(input int t, input logic [63:0] v);
      logic [63:0] cur;
      cur = band_acc.exists(t) ? band_acc[t] : 64'd0;
      band_acc[t] = fp64_sum(cur, v);
   endfunction

   function automatic rsp_item_type predict_rsp(input req_item_type q);
      rsp_item_type r;
      int        npe, dpn, f, bw, t;
      longint    ga, gb, lo, hi;
      bit        drop;
      r = '{rd: 64'd0, oob: 1'b0, done: 1'b0};
      if (q.mode == MODE_INC) begin
         if (q.idx < INC_DEPTH) begin
            inc_tab[q.idx] = q.node;
            inc_set[q.idx] = 1'b1;
         end
      end else if (q.mode == MODE_READ) begin
         if (q.idx < BAND_DEPTH && band_acc.exists(q.idx)) r.rd = band_acc[q.idx];
      end else if (q.mode == MODE_STIF) begin
         npe = eff_npe();
         dpn = eff_dpn();
         f = npe * dpn;
         bw = (cfg_bw > MAX_BAND_DEF) ? MAX_BAND_DEF : cfg_bw;
         if (loc_row < 1 || loc_row > f) begin
            loc_row = 1;
            loc_col = 1;
         end
         if (loc_col < loc_row || loc_col > f) loc_col = loc_row;
         ga = global_dof(q.elem, loc_row, npe, dpn);
         gb = global_dof(q.elem, loc_col, npe, dpn);
         lo = (ga < gb) ? ga : gb;
         hi = (ga < gb) ? gb : ga;
         drop = (lo < 1 || hi > MAX_GDOF || (hi - lo) >= bw);
         if (!drop) begin
            t = int'((lo - 1) * bw + (hi - lo));
            if (t >= BAND_DEPTH) drop = 1'b1;
            else begin
               band_add(t, q.val);
               if (loc_row != loc_col && ga == gb) band_add(t, q.val);
               band_hits.push_back(t);
            end
         end
         r.oob = drop;
         loc_col++;
         if (loc_col > f) begin
            loc_row++;
            loc_col = loc_row;
            if (loc_row > f) begin
               loc_row = 1;
               loc_col = 1;
               r.done = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic bit elem_ready(input int e);
      int slot;
      if (e == 0) return 1'b1;
      for (int nl = 0; nl < eff_npe(); nl++) begin
         slot = (e - 1) * eff_npe() + nl;
         if (slot < INC_DEPTH && !inc_set[slot]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [63:0] rand_stiffness();
      if ($urandom_range(9) == 0) return {$urandom, $urandom};
      return $realtobits((real'($urandom_range(2000)) - 1000.0) / 8.0);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[63:0], 64'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[63:0] !== want.rd)
               report_mismatch("read_value", rsp_tdata[63:0], want.rd);
            if (rsp_tdata[64] !== want.oob)
               report_mismatch("out_of_band", 64'(rsp_tdata[64]), 64'(want.oob));
            if (rsp_tdata[65] !== want.done)
               report_mismatch("element_done", 64'(rsp_tdata[65]), 64'(want.done));
         end
      end
   end

   task automatic send_req(input req_item_type q);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, q.val, q.elem, q.node, q.idx, q.mode};
      pending_rsp.push_back(predict_rsp(q));
      sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_fields(input logic [1:0] mode, input int idx, input int node,
                              input int elem, input logic [63:0] val);
      req_item_type q;
      q = '{mode: mode, idx: 17'(idx), node: 9'(node), elem: 11'(elem), val: val};
      send_req(q);
   endtask

   task automatic drain_rsp();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] data);
      drain_rsp();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NPE: cfg_npe = data[3:0];
         CSR_DPN: cfg_dpn = data[2:0];
         CSR_BW:  cfg_bw = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input int npe, input int dpn, input int bw);
      write_csr(CSR_NPE, 7'(npe));
      write_csr(CSR_DPN, 7'(dpn));
      write_csr(CSR_BW, 7'(bw));
   endtask

   task automatic run_element(input int max_items);
      int e, base, node, f, n;
      e = $urandom_range(1, MAX_ELEMENTS_DEF);
      base = $urandom_range(1, 240);
      for (int nl = 0; nl < eff_npe(); nl++) begin
         case ($urandom_range(19))
            0: node = 0;
            1: node = 511;
            2: node = $urandom_range(511);
            default: node = base + $urandom_range(15);
         endcase
         send_fields(MODE_INC, (e - 1) * eff_npe() + nl, node, 0, 64'd0);
      end
      f = eff_npe() * eff_dpn();
      n = f * (f + 1) / 2;
      if (n > max_items) n = $urandom_range(1, max_items);
      repeat (n) send_fields(MODE_STIF, 0, 0, e, rand_stiffness());
   endtask

   task automatic send_noise();
      int e, a;
      case ($urandom_range(5))
         0: send_fields(MODE_INC, $urandom_range(131071), $urandom_range(511), 0,
                        {$urandom, $urandom});
         1: begin
            a = (band_hits.size() != 0 && $urandom_range(3) != 0) ?
                band_hits[$urandom_range(band_hits.size() - 1)] : $urandom_range(131071);
            send_fields(MODE_READ, a, 0, 0, 64'd0);
         end
         2: send_fields(MODE_NONE, $urandom_range(131071), $urandom_range(511),
                        $urandom_range(2047), {$urandom, $urandom});
         3: begin
            e = (eff_npe() == MAX_NPE_DEF) ? $urandom_range(1025, 2047) : 0;
            send_fields(MODE_STIF, 0, 0, e, rand_stiffness());
         end
         default: begin
            e = $urandom_range(MAX_ELEMENTS_DEF);
            if (!elem_ready(e)) e = 0;
            send_fields(MODE_STIF, 0, 0, e, rand_stiffness());
         end
      endcase
   endtask

   task automatic run_mix(input int count);
      int stop_at;
      stop_at = sent + count;
      while (sent < stop_at) begin
         if ($urandom_range(3) != 0) run_element(40);
         else repeat ($urandom_range(1, 6)) send_noise();
      end
   endtask

   task automatic test_directed();
      send_fields(MODE_INC, 0, 1, 0, 64'd0);
      send_fields(MODE_INC, 1, 2, 0, 64'd0);
      send_fields(MODE_INC, 2, 5, 0, 64'd0);
      send_fields(MODE_INC, 3, 5, 0, 64'd0);
      send_fields(MODE_INC, 4, 1, 0, 64'd0);
      send_fields(MODE_INC, 5, 200, 0, 64'd0);
      send_fields(MODE_INC, 6, 0, 0, 64'd0);
      send_fields(MODE_INC, 7, 511, 0, 64'd0);
      send_fields(MODE_INC, INC_DEPTH - 1, 256, 0, 64'd0);
      send_fields(MODE_INC, 131071, 511, 0, 64'd0);
      send_fields(MODE_STIF, 0, 0, 1, 64'h3ff0000000000000);
      send_fields(MODE_STIF, 0, 0, 1, 64'h8000000000000000);
      send_fields(MODE_STIF, 0, 0, 2, 64'h7fefffffffffffff);
      send_fields(MODE_STIF, 0, 0, 2, 64'h0000000000000001);
      send_fields(MODE_STIF, 0, 0, 3, 64'h7ff0000000000000);
      send_fields(MODE_STIF, 0, 0, 3, 64'hffffffffffffffff);
      send_fields(MODE_STIF, 0, 0, 4, 64'h4000000000000000);
      send_fields(MODE_STIF, 0, 0, 0, 64'h4000000000000000);
      send_fields(MODE_STIF, 0, 0, 2, 64'hc008000000000000);
      send_fields(MODE_STIF, 0, 0, 2, 64'h0000000000000000);
      send_fields(MODE_READ, 0, 0, 0, 64'd0);
      send_fields(MODE_READ, 8 * 64, 0, 0, 64'd0);
      send_fields(MODE_READ, BAND_DEPTH - 1, 0, 0, 64'd0);
      send_fields(MODE_READ, 131071, 0, 0, 64'd0);
      send_fields(MODE_NONE, 131071, 511, 2047, 64'hffffffffffffffff);
   endtask

   task automatic test_config_sweep(input int count);
      set_config(1, 1, 1);
      run_mix(count / 6);
      set_config(0, 0, 127);
      run_mix(count / 6);
      set_config(15, 7, 0);
      run_mix(count / 6);
      set_config(3, 2, 5);
      run_mix(count / 6);
      set_config(8, 6, 64);
      run_mix(count / 6);
      set_config(2, 3, 10);
      run_mix(count / 6);
   endtask

   task automatic test_hold_off(input int count);
      run_mix(count / 2);
      drain_rsp();
      run_mix(count / 2);
   endtask

   task automatic test_random(input int count);
      repeat (3) begin
         set_config($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 64));
         run_mix(count / 3);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 65;
      test_directed();
      test_config_sweep(330);
      send_idle_pct = 65;
      recv_idle_pct = 16;
      test_hold_off(150);
      test_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(300);
      drain_rsp();
      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) errors++;
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
